// File: hw/rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Types, widths and the edge operand function of the point-in-polygon
// crossing test.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int COORD_BITS = 16;
    localparam int BIAS_BITS  = 16;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    localparam int WIDE_BITS = (COORD_BITS > BIAS_BITS) ? COORD_BITS : BIAS_BITS;
    localparam int LHS_BITS  = WIDE_BITS + 2;
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = LHS_BITS + DIFF_BITS;

    // Register indexes, taken from paddr[2].
    localparam logic REG_BIAS_X = 1'b0;
    localparam logic REG_BIAS_Y = 1'b1;

    localparam logic signed [BIAS_BITS-1:0] BIAS_RESET = BIAS_BITS'(16);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [BIAS_BITS-1:0]  t_bias;
    typedef logic signed [LHS_BITS-1:0]   t_lhs;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [PROD_BITS-1:0]  t_prod;

    typedef struct packed {
        t_bias bias_x;
        t_bias bias_y;
    } t_cfg;

    typedef struct packed {
        logic  straddle;
        logic  d_pos;
        t_lhs  lhs;
        t_diff d;
        t_diff dx;
        t_diff dyp;
    } t_edge_ops;

    typedef struct packed {
        logic  straddle;
        logic  d_pos;
        t_prod lp;
        t_prod rp;
    } t_edge_prod;

    typedef struct packed {
        t_edge_ops e1;
        t_edge_ops e2;
        logic      first;
        logic      last;
    } t_ops_item;

    typedef struct packed {
        t_edge_prod e1;
        t_edge_prod e2;
        logic       first;
        logic       last;
    } t_prod_item;

    // Operands of one edge, base vertex (xi,yi), other vertex (xj,yj).
    function automatic t_edge_ops edge_ops(input t_coord xi, input t_coord yi,
                                           input t_coord xj, input t_coord yj,
                                           input t_coord px, input t_coord py,
                                           input t_bias bx, input t_bias by);
        t_edge_ops ops;
        t_lhs      yi_e;
        t_lhs      yj_e;
        t_lhs      py_e;
        t_lhs      by_e;
        logic      si;
        logic      sj;
        yi_e = t_lhs'(yi);
        yj_e = t_lhs'(yj);
        py_e = t_lhs'(py);
        by_e = t_lhs'(by);
        si = (yi_e + by_e) > py_e;
        sj = (yj_e + by_e) > py_e;
        ops.straddle = si ^ sj;
        ops.d        = t_diff'(yj) - t_diff'(yi);
        // A straddling edge never has a zero dy, so the sign bit decides.
        ops.d_pos    = ~ops.d[DIFF_BITS-1];
        ops.lhs      = t_lhs'(px) - t_lhs'(bx) - t_lhs'(xi);
        ops.dx       = t_diff'(xj) - t_diff'(xi);
        ops.dyp      = t_diff'(py) - t_diff'(yi);
        return ops;
    endfunction

endpackage

// File: hw/rtl/pip_cfg_regs.sv
// ----------------------------------------------------------------------------
// pip_cfg_regs
// APB register file holding the x and y biases.
// ----------------------------------------------------------------------------
module pip_cfg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pip_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [pip_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [pip_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready,
    output pip_pkg::t_cfg                        o_cfg
);

    pip_pkg::t_bias r_bias_x;
    pip_pkg::t_bias r_bias_y;
    logic           wr_en;

    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_x <= pip_pkg::BIAS_RESET;
            r_bias_y <= pip_pkg::BIAS_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                pip_pkg::REG_BIAS_X: r_bias_x <= pwdata[pip_pkg::BIAS_BITS-1:0];
                pip_pkg::REG_BIAS_Y: r_bias_y <= pwdata[pip_pkg::BIAS_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            pip_pkg::REG_BIAS_X: prdata = pip_pkg::APB_DATA_BITS'(r_bias_x);
            pip_pkg::REG_BIAS_Y: prdata = pip_pkg::APB_DATA_BITS'(r_bias_y);
            default:             prdata = '0;
        endcase
    end

    assign o_cfg.bias_x = r_bias_x;
    assign o_cfg.bias_y = r_bias_y;

endmodule

// File: hw/rtl/pip_edge_prep.sv
// ----------------------------------------------------------------------------
// pip_edge_prep
// Polygon state and the operand register of both edges of each item.
// ----------------------------------------------------------------------------
module pip_edge_prep (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pip_pkg::t_cfg         i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  pip_pkg::t_coord       i_point_x,
    input  pip_pkg::t_coord       i_point_y,
    input  pip_pkg::t_coord       i_vertex_x,
    input  pip_pkg::t_coord       i_vertex_y,
    input  logic                  i_first_vertex,
    input  logic                  i_last_vertex,
    input  logic                  i_next_free,
    output logic                  o_valid,
    output pip_pkg::t_ops_item    o_item
);

    pip_pkg::t_coord    r_held_x, r_held_y;
    pip_pkg::t_coord    r_start_x, r_start_y;
    pip_pkg::t_coord    r_prior_x, r_prior_y;
    logic               r_valid;
    pip_pkg::t_ops_item r_item;

    pip_pkg::t_coord    n_held_x, n_held_y;
    pip_pkg::t_coord    n_start_x, n_start_y;
    pip_pkg::t_ops_item n_item;
    logic               accept;

    assign o_ready = ~r_valid | i_next_free;
    assign accept  = i_valid & o_ready;

    always_comb begin
        n_held_x  = i_first_vertex ? i_point_x  : r_held_x;
        n_held_y  = i_first_vertex ? i_point_y  : r_held_y;
        n_start_x = i_first_vertex ? i_vertex_x : r_start_x;
        n_start_y = i_first_vertex ? i_vertex_y : r_start_y;
        // Edge from the current vertex back to the previous one.
        n_item.e1 = pip_pkg::edge_ops(i_vertex_x, i_vertex_y, r_prior_x, r_prior_y,
                                      r_held_x, r_held_y, i_cfg.bias_x, i_cfg.bias_y);
        if (i_first_vertex) begin
            n_item.e1.straddle = 1'b0;
        end
        // Closing edge from the first vertex to the current one; only the last
        // item counts it.
        n_item.e2 = pip_pkg::edge_ops(n_start_x, n_start_y, i_vertex_x, i_vertex_y,
                                      n_held_x, n_held_y, i_cfg.bias_x, i_cfg.bias_y);
        if (!i_last_vertex) begin
            n_item.e2.straddle = 1'b0;
        end
        n_item.first = i_first_vertex;
        n_item.last  = i_last_vertex;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_x  <= '0;
            r_held_y  <= '0;
            r_start_x <= '0;
            r_start_y <= '0;
            r_prior_x <= '0;
            r_prior_y <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_held_x  <= n_held_x;
                r_held_y  <= n_held_y;
                r_start_x <= n_start_x;
                r_start_y <= n_start_y;
                r_prior_x <= i_vertex_x;
                r_prior_y <= i_vertex_y;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: hw/rtl/pip_edge_mul.sv
// ----------------------------------------------------------------------------
// pip_edge_mul
// Cross-multiplication stage: the left and right products of both edges.
// ----------------------------------------------------------------------------
module pip_edge_mul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  pip_pkg::t_ops_item    i_item,
    output logic                  o_free,
    input  logic                  i_next_take,
    output logic                  o_valid,
    output pip_pkg::t_prod_item   o_item
);

    logic                r_valid;
    pip_pkg::t_prod_item r_item;
    pip_pkg::t_prod_item n_item;

    function automatic pip_pkg::t_edge_prod mul_edge(input pip_pkg::t_edge_ops ops);
        pip_pkg::t_edge_prod p;
        pip_pkg::t_prod      a;
        pip_pkg::t_prod      b;
        pip_pkg::t_prod      c;
        pip_pkg::t_prod      e;
        a = pip_pkg::t_prod'(ops.lhs);
        b = pip_pkg::t_prod'(ops.d);
        c = pip_pkg::t_prod'(ops.dx);
        e = pip_pkg::t_prod'(ops.dyp);
        p.straddle = ops.straddle;
        p.d_pos    = ops.d_pos;
        p.lp       = a * b;
        p.rp       = c * e;
        return p;
    endfunction

    assign o_free = ~r_valid | i_next_take;

    always_comb begin
        n_item.e1    = mul_edge(i_item.e1);
        n_item.e2    = mul_edge(i_item.e2);
        n_item.first = i_item.first;
        n_item.last  = i_item.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: hw/rtl/pip_parity_out.sv
// ----------------------------------------------------------------------------
// pip_parity_out
// Crossing decision, parity register and the result register.
// ----------------------------------------------------------------------------
module pip_parity_out (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  pip_pkg::t_prod_item   i_item,
    output logic                  o_take,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_inside_res
);

    logic r_parity;
    logic r_out_valid;
    logic r_inside;
    logic n_parity;
    logic cross1;
    logic cross2;

    function automatic logic crosses(input pip_pkg::t_edge_prod p);
        pip_pkg::t_prod l;
        pip_pkg::t_prod r;
        logic           c;
        l = p.lp;
        r = p.rp;
        // The sign of dy sets the direction of the compare.
        c = p.d_pos ? (l < r) : (r < l);
        return p.straddle & c;
    endfunction

    assign cross1 = crosses(i_item.e1);
    assign cross2 = crosses(i_item.e2);
    assign o_take = i_valid & (~i_item.last | ~r_out_valid | i_out_ready);

    always_comb begin
        n_parity = (i_item.first ? 1'b0 : (r_parity ^ cross1)) ^ cross2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_parity <= n_parity;
            end
            if (o_take && i_item.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_item.last) begin
            r_inside <= n_parity;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_inside;

endmodule

// File: hw/rtl/point_in_polygon_crossing_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test
// Even-odd crossing test of a query point against a polygon streamed one
// vertex per item.
// ----------------------------------------------------------------------------
// The block takes one vertex item in every clock cycle for as long as the
// result side keeps up. Each item passes through three registered stages: an
// operand stage that keeps the polygon state and forms the differences of
// both edges, a multiply stage with four independent products, and the
// crossing and parity stage that also holds the result register. The result
// of a polygon is registered there after its last vertex item has passed
// the operand and multiply registers. Only a last item waits on the result
// register, so the input stalls only while a result is held there and the
// next last item has reached the parity stage. Items not marked last give
// no result, and the parity carries on until the next first item. The bias
// registers are read by the operand stage, so they should only be written
// while the block is idle.
module point_in_polygon_crossing_test (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pip_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [pip_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [pip_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  pip_pkg::t_coord                      i_point_x,
    input  pip_pkg::t_coord                      i_point_y,
    input  pip_pkg::t_coord                      i_vertex_x,
    input  pip_pkg::t_coord                      i_vertex_y,
    input  logic                                 i_first_vertex,
    input  logic                                 i_last_vertex,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_inside_res
);

    pip_pkg::t_cfg       cfg;
    logic                ops_valid;
    pip_pkg::t_ops_item  ops_item;
    logic                mul_free;
    logic                prod_valid;
    pip_pkg::t_prod_item prod_item;
    logic                par_take;

    pip_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pip_edge_prep u_prep (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_vertex_x     (i_vertex_x),
        .i_vertex_y     (i_vertex_y),
        .i_first_vertex (i_first_vertex),
        .i_last_vertex  (i_last_vertex),
        .i_next_free    (mul_free),
        .o_valid        (ops_valid),
        .o_item         (ops_item)
    );

    pip_edge_mul u_mul (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (ops_valid),
        .i_item      (ops_item),
        .o_free      (mul_free),
        .i_next_take (par_take),
        .o_valid     (prod_valid),
        .o_item      (prod_item)
    );

    pip_parity_out u_par (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (prod_valid),
        .i_item       (prod_item),
        .o_take       (par_take),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_inside_res (o_inside_res)
    );

endmodule
